// ===== src/nac_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nac_pkg: shared types and codes of the nibble accumulator execute core
// Opcode and subopcode numbering, fault codes and the structs that carry the
// operand snapshot into the execute logic and its decisions back out.
// ----------------------------------------------------------------------------
package nac_pkg;

    // primary opcodes, instr_high[7:4]
    localparam logic [3:0] OP_LDI = 4'd0;
    localparam logic [3:0] OP_LDR = 4'd1;
    localparam logic [3:0] OP_STR = 4'd2;
    localparam logic [3:0] OP_XCH = 4'd3;
    localparam logic [3:0] OP_SRC = 4'd4;
    localparam logic [3:0] OP_ADD = 4'd5;
    localparam logic [3:0] OP_SUB = 4'd6;
    localparam logic [3:0] OP_AND = 4'd7;
    localparam logic [3:0] OP_OR  = 4'd8;
    localparam logic [3:0] OP_XOR = 4'd9;
    localparam logic [3:0] OP_JSR = 4'd10;
    localparam logic [3:0] OP_JZ  = 4'd11;
    localparam logic [3:0] OP_JNZ = 4'd12;
    localparam logic [3:0] OP_JUC = 4'd13;
    localparam logic [3:0] OP_JR  = 4'd14;
    localparam logic [3:0] OP_EXT = 4'd15;

    // extended subopcodes, instr_high[3:0] under OP_EXT
    localparam logic [3:0] SUB_STM  = 4'd0;
    localparam logic [3:0] SUB_LDM  = 4'd1;
    localparam logic [3:0] SUB_MOV  = 4'd2;
    localparam logic [3:0] SUB_XCHR = 4'd3;
    localparam logic [3:0] SUB_NOT  = 4'd4;
    localparam logic [3:0] SUB_RCR  = 4'd5;
    localparam logic [3:0] SUB_RCL  = 4'd6;
    localparam logic [3:0] SUB_RET  = 4'd7;
    localparam logic [3:0] SUB_SHR  = 4'd8;
    localparam logic [3:0] SUB_SHL  = 4'd9;
    localparam logic [3:0] SUB_NOP  = 4'd10;
    localparam logic [3:0] SUB_HALT = 4'd11;

    // fault codes
    localparam logic [1:0] FAULT_NONE      = 2'd0;
    localparam logic [1:0] FAULT_UNKNOWN   = 2'd1;
    localparam logic [1:0] FAULT_UNDERFLOW = 2'd2;
    localparam logic [1:0] FAULT_OVERFLOW  = 2'd3;

    // operand snapshot handed to the execute logic
    typedef struct packed {
        logic [7:0]  instr_high;
        logic [7:0]  instr_low;
        logic [11:0] pc;
        logic [11:0] jump_tgt;   // argument already reduced mod program size
        logic [11:0] stack_top;
        logic [3:0]  acc;
        logic        carry;
        logic [3:0]  src_val;
        logic [3:0]  dst_val;
        logic [3:0]  ram_val;
        logic        sp_empty;
        logic        sp_full;
        logic        halted;
    } t_exe_in;

    // new state and write strobes from the execute logic
    typedef struct packed {
        logic [11:0] pc;
        logic [11:0] ret_pc;
        logic [3:0]  acc;
        logic        carry;
        logic        halted;
        logic [1:0]  fault;
        logic        dst_we;
        logic [3:0]  dst_data;
        logic        src_we;
        logic [3:0]  src_data;
        logic        ram_we;
        logic        dal_we;
        logic        push;
        logic        pop;
    } t_exe_out;

endpackage
`default_nettype wire

// ===== src/nac_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nac_if: valid/ready channels of the execute core
// nac_in_if carries one instruction word, nac_out_if one result word.
// ----------------------------------------------------------------------------
interface nac_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] instr_high;
    logic [7:0] instr_low;

    modport source (output valid, output instr_high, output instr_low, input ready);
    modport sink   (input valid, input instr_high, input instr_low, output ready);
endinterface

interface nac_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] next_pc;
    logic [3:0]  acc_value;
    logic        carry_flag;
    logic        halted;
    logic [1:0]  fault;

    modport source (output valid, output next_pc, output acc_value, output carry_flag,
                    output halted, output fault, input ready);
    modport sink   (input valid, input next_pc, input acc_value, input carry_flag,
                    input halted, input fault, output ready);
endinterface
`default_nettype wire

// ===== src/nac_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nac_ram: generic simple dual-port RAM
// One write port, one read port with registered read data (old data on a
// read of the address being written).
// ----------------------------------------------------------------------------
module nac_ram #(
    parameter int WIDTH  = 4,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== src/nac_exec.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nac_exec: instruction execute logic
// Decodes one instruction against the operand snapshot and gives the new
// accumulator, carry, PC, halt flag, fault code and all write strobes.
// ----------------------------------------------------------------------------
module nac_exec import nac_pkg::*; #(
    parameter int PROG_BYTES = 4096
) (
    input  wire t_exe_in  i_x,
    output t_exe_out      o_y
);

    localparam logic [12:0] PB13 = 13'(PROG_BYTES);
    localparam logic [13:0] PB14 = 14'(PROG_BYTES);

    logic [3:0]  op;
    logic [3:0]  sub;
    logic [12:0] seq13;
    logic [11:0] seq_pc;
    logic [13:0] rel0;
    logic [13:0] rel1;
    logic [13:0] rel2;
    logic [4:0]  sum5;
    logic [11:0] npc;
    t_exe_out    y;

    assign op  = i_x.instr_high[7:4];
    assign sub = i_x.instr_high[3:0];

    // sequential PC, wraps at program size
    assign seq13  = {1'b0, i_x.pc} + 13'd2;
    assign seq_pc = (seq13 >= PB13) ? 12'(seq13 - PB13) : seq13[11:0];

    // relative target: PC + 2 + offset, biased by one program size, then folded
    assign rel0 = {2'b00, i_x.pc} + 14'd2 + PB14 + {{6{i_x.instr_low[7]}}, i_x.instr_low};
    assign rel1 = (rel0 >= PB14) ? rel0 - PB14 : rel0;
    assign rel2 = (rel1 >= PB14) ? rel1 - PB14 : rel1;

    assign sum5 = {1'b0, i_x.acc} + {1'b0, i_x.dst_val};

    always_comb begin
        y          = '0;
        y.acc      = i_x.acc;
        y.carry    = i_x.carry;
        y.halted   = i_x.halted;
        y.fault    = FAULT_NONE;
        y.ret_pc   = seq_pc;
        y.dst_data = i_x.acc;
        y.src_data = i_x.dst_val;
        npc        = seq_pc;

        if (!i_x.halted) begin
            case (op)
                OP_LDI: y.acc = i_x.instr_low[3:0];
                OP_LDR: y.acc = i_x.dst_val;
                OP_STR: y.dst_we = 1'b1;
                OP_XCH: begin
                    y.dst_we = 1'b1;
                    y.acc    = i_x.dst_val;
                end
                OP_SRC: y.dal_we = 1'b1;
                OP_ADD: begin
                    y.acc   = sum5[3:0];
                    y.carry = sum5[4];
                end
                OP_SUB: begin
                    y.acc   = i_x.acc - i_x.dst_val;
                    y.carry = (i_x.dst_val > i_x.acc);
                end
                OP_AND: y.acc = i_x.acc & i_x.dst_val;
                OP_OR:  y.acc = i_x.acc | i_x.dst_val;
                OP_XOR: y.acc = i_x.acc ^ i_x.dst_val;
                OP_JSR: begin
                    if (i_x.sp_full) begin
                        y.fault = FAULT_OVERFLOW;
                    end else begin
                        y.push = 1'b1;
                        npc    = i_x.jump_tgt;
                    end
                end
                OP_JZ:  if (i_x.acc == 4'd0) npc = i_x.jump_tgt;
                OP_JNZ: if (i_x.acc != 4'd0) npc = i_x.jump_tgt;
                OP_JUC: npc = i_x.jump_tgt;
                OP_JR:  npc = rel2[11:0];
                OP_EXT: begin
                    case (sub)
                        SUB_STM: y.ram_we = 1'b1;
                        SUB_LDM: y.acc = i_x.ram_val;
                        SUB_MOV: begin
                            y.dst_we   = 1'b1;
                            y.dst_data = i_x.src_val;
                        end
                        SUB_XCHR: begin
                            y.dst_we   = 1'b1;
                            y.dst_data = i_x.src_val;
                            y.src_we   = 1'b1;
                            y.src_data = i_x.dst_val;
                        end
                        SUB_NOT: y.acc = ~i_x.acc;
                        SUB_RCR: begin
                            y.acc   = {i_x.carry, i_x.acc[3:1]};
                            y.carry = i_x.acc[0];
                        end
                        SUB_RCL: begin
                            y.acc   = {i_x.acc[2:0], i_x.carry};
                            y.carry = i_x.acc[3];
                        end
                        SUB_RET: begin
                            if (i_x.sp_empty) begin
                                y.fault = FAULT_UNDERFLOW;
                            end else begin
                                y.pop = 1'b1;
                                npc   = i_x.stack_top;
                            end
                        end
                        SUB_SHR: y.acc = (i_x.instr_low >= 8'd4) ? 4'd0
                                         : i_x.acc >> i_x.instr_low[1:0];
                        SUB_SHL: y.acc = (i_x.instr_low >= 8'd4) ? 4'd0
                                         : i_x.acc << i_x.instr_low[1:0];
                        SUB_NOP: ;
                        SUB_HALT: begin
                            y.halted = 1'b1;
                            npc      = i_x.pc;
                        end
                        default: y.fault = FAULT_UNKNOWN;
                    endcase
                end
                default: ;
            endcase
        end

        // a faulting or halted word leaves the PC where it is
        y.pc = (y.fault == FAULT_NONE && !i_x.halted) ? npc : i_x.pc;
    end

    assign o_y = y;

endmodule
`default_nettype wire

// ===== src/nibble_accumulator_cpu_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nibble_accumulator_cpu_step: execute core of a 4-bit accumulator processor
// One instruction word in, one result word (next PC, accumulator, carry,
// halted, fault) out, with data RAM, register file and return stack inside.
// ----------------------------------------------------------------------------
// Each accepted instruction word yields exactly one result word, by way of the
// input register, then the result register, and a new word can be taken
// every cycle while the result side keeps up. After reset the core clears its
// data RAM one word a cycle, and input ready stays low until the last word is
// cleared, so no instruction is taken before then. The data RAM and the return
// stack are RAMs with registered reads; their read ports are steered to the next
// address in advance and a one-word bypass covers a write just made, so that
// neither holds up the core. PROG_BYTES and DATA_WORDS need not be powers of two.
// ----------------------------------------------------------------------------
module nibble_accumulator_cpu_step import nac_pkg::*; #(
    parameter int DATA_WORDS  = 256,
    parameter int PROG_BYTES  = 4096,
    parameter int REG_COUNT   = 16,
    parameter int STACK_DEPTH = 8
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    nac_in_if.sink     i_in,
    nac_out_if.source  o_out
);

    localparam int DAW = $clog2(DATA_WORDS);
    localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int RIW = $clog2(REG_COUNT);

    // scaled reciprocals, 2^24 / divisor rounded up
    localparam logic [20:0] PB_RECIP = 21'((2**24 + PROG_BYTES - 1) / PROG_BYTES);
    localparam logic [20:0] DW_RECIP = 21'((2**24 + DATA_WORDS - 1) / DATA_WORDS);

    // remainder of a 12-bit value by a constant: reciprocal multiply for the
    // quotient, then multiply back and subtract
    function automatic logic [11:0] f_reduce(input logic [11:0] x, input logic [12:0] d,
                                             input logic [20:0] m);
        logic [32:0] prod;
        logic [21:0] back;
        prod = {21'd0, x} * {12'd0, m};
        back = {13'd0, prod[32:24]} * {9'd0, d};
        return x - back[11:0];
    endfunction

    // input register
    logic           r_in_valid;
    logic [7:0]     r_hi;
    logic [7:0]     r_lo;
    logic [11:0]    r_tgt;
    logic [DAW-1:0] r_dal_arg;

    // architectural state
    logic [11:0]    r_pc;
    logic [3:0]     r_acc;
    logic           r_carry;
    logic [DAW-1:0] r_dal;
    logic [3:0]     r_regs [REG_COUNT];
    logic [SPW-1:0] r_sp;
    logic           r_halted;

    // clearing pass and RAM bypasses
    logic           r_clr_busy;
    logic [DAW-1:0] r_clr_addr;
    logic           r_ram_fwd;
    logic [3:0]     r_ram_fwd_data;
    logic           r_stk_fwd;
    logic [11:0]    r_stk_fwd_data;

    // result register
    logic           r_out_valid;
    logic [11:0]    r_out_pc;
    logic [3:0]     r_out_acc;
    logic           r_out_carry;
    logic           r_out_halted;
    logic [1:0]     r_out_fault;

    logic           fire;
    logic           in_take;
    logic [11:0]    in_arg;
    logic [DAW-1:0] n_dal;
    logic [SPW-1:0] n_sp;
    logic           ram_we;
    logic [DAW-1:0] ram_waddr;
    logic [3:0]     ram_wdata;
    logic [3:0]     ram_rdata;
    logic [SAW-1:0] stk_raddr;
    logic [11:0]    stk_rdata;
    t_exe_in        ex_in;
    t_exe_out       ex_out;

    // handshake
    assign fire       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_clr_busy && (!r_in_valid || fire);
    assign in_take    = i_in.valid && i_in.ready;
    assign in_arg     = {i_in.instr_high[3:0], i_in.instr_low};

    // input register; jump and latch arguments are reduced on the way in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_hi      <= i_in.instr_high;
            r_lo      <= i_in.instr_low;
            r_tgt     <= f_reduce(in_arg, 13'(PROG_BYTES), PB_RECIP);
            r_dal_arg <= DAW'(f_reduce(in_arg, 13'(DATA_WORDS), DW_RECIP));
        end
    end

    // operand snapshot
    always_comb begin
        ex_in            = '0;
        ex_in.instr_high = r_hi;
        ex_in.instr_low  = r_lo;
        ex_in.pc         = r_pc;
        ex_in.jump_tgt   = r_tgt;
        ex_in.stack_top  = r_stk_fwd ? r_stk_fwd_data : stk_rdata;
        ex_in.acc        = r_acc;
        ex_in.carry      = r_carry;
        ex_in.src_val    = r_regs[r_lo[4 +: RIW]];
        ex_in.dst_val    = r_regs[r_lo[0 +: RIW]];
        ex_in.ram_val    = r_ram_fwd ? r_ram_fwd_data : ram_rdata;
        ex_in.sp_empty   = (r_sp == '0);
        ex_in.sp_full    = (r_sp == SPW'(STACK_DEPTH));
        ex_in.halted     = r_halted;
    end

    nac_exec #(
        .PROG_BYTES (PROG_BYTES)
    ) u_exec (
        .i_x (ex_in),
        .o_y (ex_out)
    );

    // next latch and stack pointer, used to steer the RAM read ports ahead
    assign n_dal = (fire && ex_out.dal_we) ? r_dal_arg : r_dal;
    always_comb begin
        n_sp = r_sp;
        if (fire && ex_out.push) n_sp = r_sp + SPW'(1);
        if (fire && ex_out.pop)  n_sp = r_sp - SPW'(1);
    end
    assign stk_raddr = (n_sp == '0) ? '0 : SAW'(n_sp - SPW'(1));

    // architectural state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= '0;
            r_acc    <= '0;
            r_carry  <= 1'b0;
            r_dal    <= '0;
            r_sp     <= '0;
            r_halted <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++) r_regs[i] <= '0;
        end else begin
            r_dal <= n_dal;
            r_sp  <= n_sp;
            if (fire) begin
                r_pc     <= ex_out.pc;
                r_acc    <= ex_out.acc;
                r_carry  <= ex_out.carry;
                r_halted <= ex_out.halted;
                if (ex_out.src_we) r_regs[r_lo[4 +: RIW]] <= ex_out.src_data;
                if (ex_out.dst_we) r_regs[r_lo[0 +: RIW]] <= ex_out.dst_data;
            end
        end
    end

    // clearing pass over the data RAM after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + DAW'(1);
            if (r_clr_addr == DAW'(DATA_WORDS - 1)) r_clr_busy <= 1'b0;
        end
    end

    // bypass words for a RAM write made in the previous cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_fwd <= 1'b0;
            r_stk_fwd <= 1'b0;
        end else begin
            r_ram_fwd <= r_clr_busy || (fire && ex_out.ram_we);
            r_stk_fwd <= fire && ex_out.push;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ram_fwd_data <= r_clr_busy ? 4'd0 : r_acc;
        r_stk_fwd_data <= ex_out.ret_pc;
    end

    // data RAM
    assign ram_we    = r_clr_busy || (fire && ex_out.ram_we);
    assign ram_waddr = r_clr_busy ? r_clr_addr : r_dal;
    assign ram_wdata = r_clr_busy ? 4'd0 : r_acc;

    nac_ram #(
        .WIDTH (4),
        .DEPTH (DATA_WORDS)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_dal),
        .o_rdata (ram_rdata)
    );

    // return stack
    nac_ram #(
        .WIDTH (12),
        .DEPTH (STACK_DEPTH)
    ) u_ret_stack (
        .i_clk   (i_clk),
        .i_we    (fire && ex_out.push),
        .i_waddr (SAW'(r_sp)),
        .i_wdata (ex_out.ret_pc),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_pc     <= ex_out.pc;
            r_out_acc    <= ex_out.acc;
            r_out_carry  <= ex_out.carry;
            r_out_halted <= ex_out.halted;
            r_out_fault  <= ex_out.fault;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.next_pc    = r_out_pc;
    assign o_out.acc_value  = r_out_acc;
    assign o_out.carry_flag = r_out_carry;
    assign o_out.halted     = r_out_halted;
    assign o_out.fault      = r_out_fault;

    // checks
    a_fault_holds_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && ex_out.fault != FAULT_NONE) |=> (r_pc == $past(r_pc)))
        else $error("faulting word moved the PC");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halted flag dropped");

    a_no_take_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !i_in.ready)
        else $error("word taken during RAM clearing pass");

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && ex_out.push) |=> (r_sp == $past(r_sp) + SPW'(1)))
        else $error("call did not advance the stack pointer");

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the nibble accumulator execute core
// Instruction words go in over a valid/ready channel. Every accepted word is
// run through a behavioural copy of the core, and each result word is checked
// field by field against the oldest outstanding prediction. The run starts
// with a short table of directed words, some with the result written out by
// hand. Random call/return bursts, memory and ALU sequences and raw noise
// follow. It ends with HALT and a few words that a halted core must ignore.
// Source gaps and sink stalls vary by phase.
// ----------------------------------------------------------------------------
module tb import nac_pkg::*; ();

    localparam int DATA_WORDS  = 256;
    localparam int PROG_BYTES  = 4096;
    localparam int REG_COUNT   = 16;
    localparam int STACK_DEPTH = 8;
    localparam int RANDOM_WORDS = 700;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 60000;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [11:0] next_pc;
        logic [3:0]  acc_value;
        logic        carry_flag;
        logic        halted;
        logic [1:0]  fault;
    } t_cpu_result;

    typedef struct packed {
        logic [7:0]  instr_high;
        logic [7:0]  instr_low;
        logic        typed;
        t_cpu_result result;
    } t_dir_word;

    logic i_clk;
    logic i_rst_n;

    nac_in_if  in_ch ();
    nac_out_if out_ch ();

    nibble_accumulator_cpu_step #(
        .DATA_WORDS  (DATA_WORDS),
        .PROG_BYTES  (PROG_BYTES),
        .REG_COUNT   (REG_COUNT),
        .STACK_DEPTH (STACK_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // shadow copy of the core state
    logic [11:0] pc_st;
    logic [3:0]  acc_st;
    logic        carry_st;
    logic [11:0] dal_st;
    logic [3:0]  reg_st [REG_COUNT];
    logic [3:0]  mem_st [DATA_WORDS];
    logic [11:0] stk_st [STACK_DEPTH];
    int          sp_st;
    logic        halt_st;

    t_cpu_result pending_results [$];
    t_dir_word   dir_words [$];

    // hand-written expectation travels with the word being offered
    logic        drv_typed;
    t_cpu_result drv_result;

    int send_idle_pct;
    int recv_stall_pct;
    int words_sent;
    int error_count;
    int cycle_count;

    // clock, 2 ns period
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // one instruction against the shadow state
    function automatic t_cpu_result execute_instr(input logic [7:0] hi, input logic [7:0] lo);
        logic [3:0]  op;
        logic [3:0]  sub;
        logic [3:0]  ridx;
        logic [3:0]  rsrc;
        logic [3:0]  rdst;
        logic [3:0]  tmp;
        logic        bit_out;
        logic [4:0]  sum;
        logic [11:0] arg12;
        logic [11:0] npc;
        logic [1:0]  flt;
        t_cpu_result res;
        op    = hi[7:4];
        sub   = hi[3:0];
        arg12 = {hi[3:0], lo};
        ridx  = lo[3:0];
        rsrc  = lo[7:4];
        rdst  = lo[3:0];
        flt   = FAULT_NONE;
        if (!halt_st) begin
            npc = 12'((int'(pc_st) + 2) % PROG_BYTES);
            case (op)
                OP_LDI: acc_st = arg12[3:0];
                OP_LDR: acc_st = reg_st[ridx];
                OP_STR: reg_st[ridx] = acc_st;
                OP_XCH: begin
                    tmp = reg_st[ridx];
                    reg_st[ridx] = acc_st;
                    acc_st = tmp;
                end
                OP_SRC: dal_st = arg12;
                OP_ADD: begin
                    sum = {1'b0, acc_st} + {1'b0, reg_st[ridx]};
                    acc_st = sum[3:0];
                    carry_st = sum[4];
                end
                OP_SUB: begin
                    carry_st = (reg_st[ridx] > acc_st);
                    acc_st = acc_st - reg_st[ridx];
                end
                OP_AND: acc_st = acc_st & reg_st[ridx];
                OP_OR:  acc_st = acc_st | reg_st[ridx];
                OP_XOR: acc_st = acc_st ^ reg_st[ridx];
                OP_JSR: begin
                    if (sp_st >= STACK_DEPTH) begin
                        flt = FAULT_OVERFLOW;
                    end else begin
                        stk_st[sp_st] = npc;
                        sp_st++;
                        npc = 12'(int'(arg12) % PROG_BYTES);
                    end
                end
                OP_JZ:  if (acc_st == 4'd0) npc = 12'(int'(arg12) % PROG_BYTES);
                OP_JNZ: if (acc_st != 4'd0) npc = 12'(int'(arg12) % PROG_BYTES);
                OP_JUC: npc = 12'(int'(arg12) % PROG_BYTES);
                OP_JR:  npc = 12'((int'(pc_st) + 2 + PROG_BYTES + int'($signed(lo)))
                              % PROG_BYTES);
                default: begin
                    case (sub)
                        SUB_STM: mem_st[int'(dal_st) % DATA_WORDS] = acc_st;
                        SUB_LDM: acc_st = mem_st[int'(dal_st) % DATA_WORDS];
                        SUB_MOV: reg_st[rdst] = reg_st[rsrc];
                        SUB_XCHR: begin
                            tmp = reg_st[rdst];
                            reg_st[rdst] = reg_st[rsrc];
                            reg_st[rsrc] = tmp;
                        end
                        SUB_NOT: acc_st = ~acc_st;
                        SUB_RCR: begin
                            bit_out = acc_st[0];
                            acc_st = {carry_st, acc_st[3:1]};
                            carry_st = bit_out;
                        end
                        SUB_RCL: begin
                            bit_out = acc_st[3];
                            acc_st = {acc_st[2:0], carry_st};
                            carry_st = bit_out;
                        end
                        SUB_RET: begin
                            if (sp_st == 0) begin
                                flt = FAULT_UNDERFLOW;
                            end else begin
                                sp_st--;
                                npc = 12'(int'(stk_st[sp_st]) % PROG_BYTES);
                            end
                        end
                        SUB_SHR: acc_st = (lo >= 8'd4) ? 4'd0 : (acc_st >> lo);
                        SUB_SHL: acc_st = (lo >= 8'd4) ? 4'd0 : (acc_st << lo);
                        SUB_NOP: ;
                        SUB_HALT: begin
                            halt_st = 1'b1;
                            npc = pc_st;
                        end
                        default: flt = FAULT_UNKNOWN;
                    endcase
                end
            endcase
            if (flt == FAULT_NONE) pc_st = npc;
        end
        res.next_pc    = pc_st;
        res.acc_value  = acc_st;
        res.carry_flag = carry_st;
        res.halted     = halt_st;
        res.fault      = flt;
        return res;
    endfunction

    function automatic t_cpu_result result_of(input logic [11:0] pc, input logic [3:0] acc,
                                              input logic c, input logic [1:0] flt);
        t_cpu_result res;
        res.next_pc    = pc;
        res.acc_value  = acc;
        res.carry_flag = c;
        res.halted     = 1'b0;
        res.fault      = flt;
        return res;
    endfunction

    function automatic void add_word(input logic [7:0] hi, input logic [7:0] lo,
                                     input logic typed, input t_cpu_result res);
        t_dir_word w;
        w.instr_high = hi;
        w.instr_low  = lo;
        w.typed      = typed;
        w.result     = res;
        dir_words.push_back(w);
    endfunction

    // idling mix: none, source gaps, sink stalls, both lightly
    function automatic void set_idle_phase(input int phase);
        case (phase)
            1:       begin send_idle_pct = 60; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 60; end
            3:       begin send_idle_pct = 18; recv_stall_pct = 18; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endfunction

    // offer one word, optional gap first, return on the accepting edge
    task automatic send_word(input logic [7:0] hi, input logic [7:0] lo,
                             input logic typed, input t_cpu_result res);
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_ch.valid      <= 1'b1;
        in_ch.instr_high <= hi;
        in_ch.instr_low  <= lo;
        drv_typed        <= typed;
        drv_result       <= res;
        do @(posedge i_clk); while (!in_ch.ready);
        words_sent++;
    endtask

    task automatic send_plain(input logic [7:0] hi, input logic [7:0] lo);
        send_word(hi, lo, 1'b0, '0);
    endtask

    // random instruction, mostly well-formed with some unknown subopcodes, never HALT
    task automatic send_random_instr();
        logic [3:0] op;
        logic [3:0] sub;
        logic [7:0] lo;
        op  = 4'($urandom_range(15));
        lo  = 8'($urandom_range(255));
        sub = 4'($urandom_range(15));
        if (op == OP_EXT) begin
            sub = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 12))
                                            : 4'($urandom_range(10));
            if ((sub == SUB_SHR || sub == SUB_SHL) && $urandom_range(1))
                lo = 8'($urandom_range(4));
        end
        send_plain({op, sub}, lo);
    endtask

    // one random sequence of words
    task automatic send_sequence();
        int kind;
        int n;
        logic [3:0] r;
        logic [7:0] hi;
        kind = $urandom_range(99);
        if (kind < 55) begin
            send_random_instr();
        end else if (kind < 67) begin
            // call burst, long ones run into a full stack
            n = $urandom_range(10, 1);
            repeat (n) send_plain({OP_JSR, 4'($urandom_range(15))}, 8'($urandom_range(255)));
        end else if (kind < 79) begin
            // return burst, long ones run past an empty stack
            n = $urandom_range(10, 1);
            repeat (n) send_plain({OP_EXT, SUB_RET}, 8'($urandom_range(255)));
        end else if (kind < 89) begin
            // latch an address, store, clobber, load back
            send_plain({OP_SRC, 4'($urandom_range(15))}, 8'($urandom_range(255)));
            send_plain({OP_LDI, 4'($urandom_range(15))}, 8'($urandom_range(255)));
            send_plain({OP_EXT, SUB_STM}, 8'($urandom_range(255)));
            send_plain({OP_LDI, 4'($urandom_range(15))}, 8'($urandom_range(255)));
            send_plain({OP_EXT, SUB_LDM}, 8'($urandom_range(255)));
        end else if (kind < 95) begin
            // arithmetic chain through a register and the carry
            r = 4'($urandom_range(15));
            send_plain({OP_LDI, 4'($urandom_range(15))}, 8'($urandom_range(255)));
            send_plain({OP_STR, 4'($urandom_range(15))}, {4'($urandom_range(15)), r});
            send_plain({OP_LDI, 4'($urandom_range(15))}, 8'($urandom_range(255)));
            send_plain({$urandom_range(1) ? OP_ADD : OP_SUB, 4'($urandom_range(15))},
                       {4'($urandom_range(15)), r});
            send_plain({OP_EXT, $urandom_range(1) ? SUB_RCR : SUB_RCL},
                       8'($urandom_range(255)));
        end else begin
            // raw noise, HALT turned into NOP
            hi = 8'($urandom_range(255));
            if (hi == {OP_EXT, SUB_HALT}) hi = {OP_EXT, SUB_NOP};
            send_plain(hi, 8'($urandom_range(255)));
        end
    endtask

    // sink side ready
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // prediction on accepted words, checking of result words, watchdog
    always @(posedge i_clk) begin
        t_cpu_result got;
        t_cpu_result want;
        t_cpu_result pred;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("nibble_accumulator_cpu_step verification failed");
            $finish;
        end
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got.next_pc    = out_ch.next_pc;
                got.acc_value  = out_ch.acc_value;
                got.carry_flag = out_ch.carry_flag;
                got.halted     = out_ch.halted;
                got.fault      = out_ch.fault;
                if (pending_results.size() == 0) begin
                    if (error_count < REPORT_MAX)
                        $display("unexpected result word: pc=%h acc=%h c=%b h=%b f=%0d",
                                 got.next_pc, got.acc_value, got.carry_flag,
                                 got.halted, got.fault);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.next_pc !== want.next_pc || got.acc_value !== want.acc_value ||
                        got.carry_flag !== want.carry_flag || got.halted !== want.halted ||
                        got.fault !== want.fault) begin
                        if (error_count < REPORT_MAX)
                            $display({"mismatch: exp pc=%h acc=%h c=%b h=%b f=%0d",
                                      " / got pc=%h acc=%h c=%b h=%b f=%0d"},
                                     want.next_pc, want.acc_value, want.carry_flag,
                                     want.halted, want.fault, got.next_pc, got.acc_value,
                                     got.carry_flag, got.halted, got.fault);
                        error_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                pred = execute_instr(in_ch.instr_high, in_ch.instr_low);
                pending_results.push_back(drv_typed ? drv_result : pred);
            end
        end
    end

    // stimulus
    initial begin
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.instr_high = 8'h00;
        in_ch.instr_low  = 8'h00;
        out_ch.ready     = 1'b0;
        drv_typed        = 1'b0;
        drv_result       = '0;
        words_sent       = 0;
        error_count      = 0;
        cycle_count      = 0;
        pc_st            = '0;
        acc_st           = '0;
        carry_st         = 1'b0;
        dal_st           = '0;
        sp_st            = 0;
        halt_st          = 1'b0;
        foreach (reg_st[i]) reg_st[i] = '0;
        foreach (mem_st[i]) mem_st[i] = '0;
        foreach (stk_st[i]) stk_st[i] = '0;
        set_idle_phase(0);

        // directed words; results out of reset are easy to write down
        add_word({OP_LDI, 4'hF}, 8'hFF, 1'b1, result_of(12'h002, 4'hF, 1'b0, FAULT_NONE));
        add_word({OP_STR, 4'h0}, 8'h0F, 1'b1, result_of(12'h004, 4'hF, 1'b0, FAULT_NONE));
        add_word({OP_ADD, 4'h0}, 8'h0F, 1'b1, result_of(12'h006, 4'hE, 1'b1, FAULT_NONE));
        add_word({OP_SUB, 4'h0}, 8'h00, 1'b0, '0);
        add_word({OP_EXT, SUB_RET}, 8'h00, 1'b1,
                 result_of(12'h008, 4'hE, 1'b0, FAULT_UNDERFLOW));
        add_word(8'hFF, 8'hFF, 1'b1, result_of(12'h008, 4'hE, 1'b0, FAULT_UNKNOWN));
        add_word({OP_SRC, 4'hF}, 8'hFF, 1'b0, '0);
        add_word({OP_EXT, SUB_STM}, 8'h00, 1'b0, '0);
        add_word({OP_JNZ, 4'h4}, 8'h56, 1'b0, '0);
        add_word({OP_LDI, 4'h0}, 8'h00, 1'b0, '0);
        add_word({OP_JZ, 4'h1}, 8'h23, 1'b0, '0);
        add_word({OP_EXT, SUB_LDM}, 8'h00, 1'b0, '0);
        add_word({OP_XCH, 4'h3}, 8'h03, 1'b0, '0);
        add_word({OP_LDR, 4'hF}, 8'hFF, 1'b0, '0);
        add_word({OP_AND, 4'hF}, 8'h0F, 1'b0, '0);
        add_word({OP_OR, 4'h0}, 8'h03, 1'b0, '0);
        add_word({OP_XOR, 4'h0}, 8'h0F, 1'b0, '0);
        add_word({OP_EXT, SUB_NOT}, 8'h00, 1'b0, '0);
        add_word({OP_EXT, SUB_RCR}, 8'h00, 1'b0, '0);
        add_word({OP_EXT, SUB_RCL}, 8'h00, 1'b0, '0);
        add_word({OP_EXT, SUB_SHR}, 8'h01, 1'b0, '0);
        add_word({OP_EXT, SUB_SHL}, 8'h04, 1'b0, '0);
        add_word({OP_EXT, SUB_MOV}, 8'hF0, 1'b0, '0);
        add_word({OP_EXT, SUB_XCHR}, 8'h0F, 1'b0, '0);
        // jump to the top of program space, then a forward relative jump that wraps and a backward one
        add_word({OP_JUC, 4'hF}, 8'hFF, 1'b0, '0);
        add_word({OP_JR, 4'h0}, 8'h7F, 1'b0, '0);
        add_word({OP_JR, 4'h0}, 8'h80, 1'b0, '0);
        add_word({OP_JSR, 4'hA}, 8'h55, 1'b0, '0);
        add_word({OP_EXT, SUB_NOP}, 8'hFF, 1'b0, '0);
        add_word({OP_EXT, SUB_RET}, 8'h00, 1'b0, '0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_words[i])
            send_word(dir_words[i].instr_high, dir_words[i].instr_low,
                      dir_words[i].typed, dir_words[i].result);

        // random part, idling phase rotates every hundred words
        while (words_sent < dir_words.size() + RANDOM_WORDS) begin
            set_idle_phase((words_sent / 100) % 4);
            send_sequence();
        end

        // halt, then words a halted core must ignore
        set_idle_phase(3);
        send_plain({OP_EXT, SUB_HALT}, 8'($urandom_range(255)));
        send_plain(8'hFF, 8'hFF);
        send_plain({OP_EXT, SUB_RET}, 8'h00);
        send_plain({OP_LDI, 4'h0}, 8'h05);
        send_plain({OP_JSR, 4'h1}, 8'h00);

        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        // any prediction still waiting is a lost result word
        error_count += pending_results.size();

        if (error_count == 0)
            $display("nibble_accumulator_cpu_step verification clean");
        else
            $display("nibble_accumulator_cpu_step verification failed");
        $finish;
    end

endmodule
